FILE: hdl/edfrm_pkg.sv
package edfrm_pkg;

  localparam int NUM_TASKS_DEF = 16;

  localparam logic [1:0] CLASS_NONE = 2'd0;
  localparam logic [1:0] CLASS_APER = 2'd1;
  localparam logic [1:0] CLASS_MED  = 2'd2;
  localparam logic [1:0] CLASS_PER  = 2'd3;

  localparam logic [1:0] ST_READY = 2'd0;
  localparam logic [1:0] ST_SUSP  = 2'd1;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_SCHED = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  // Contents of one task slot.
  typedef struct packed {
    logic [1:0]  cls;
    logic [1:0]  status;
    logic [7:0]  prio;
    logic [31:0] deadline;
  } slot_rec_t;

  // Per-cell control.
  typedef struct packed {
    logic load;   // write slot from the input beat
    logic shift;  // take neighbour's record
    logic clr;    // return status to ready
  } cell_ctrl_t;

  // Picker control.
  typedef struct packed {
    logic start;  // clear candidates
    logic step;   // examine head record
  } pick_ctrl_t;

endpackage

FILE: hdl/edfrm_if.sv
interface edfrm_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [3:0]  slot;
  logic [1:0]  task_class;
  logic [1:0]  task_status;
  logic [7:0]  priority_req;
  logic [31:0] deadline;
  logic        blocking_call;

  modport source (output valid, mode, slot, task_class, task_status, priority_req,
                  deadline, blocking_call, input ready);
  modport sink (input valid, mode, slot, task_class, task_status, priority_req,
                deadline, blocking_call, output ready);
endinterface

interface edfrm_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] chosen_slot;
  logic       found;
  logic [1:0] chosen_class;

  modport source (output valid, chosen_slot, found, chosen_class, input ready);
  modport sink (input valid, chosen_slot, found, chosen_class, output ready);
endinterface

FILE: hdl/edf_rm_task_selector.sv
// Write beat: the block stays idle and ready, so another beat may follow it directly.
// Schedule beat: the ring of slot cells rotates once past a single picker, one slot per
//   cycle; the result register is then loaded as soon as it is free.
// No new beat is taken until the result of a schedule beat has been loaded.
// Reset (rst, synchronous, active high) clears every slot to no task and drops the
//   active task; the block is ready in the cycle after reset.
module edf_rm_task_selector #(
  parameter int NUM_TASKS = edfrm_pkg::NUM_TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  edfrm_in_if.sink    task_in,
  edfrm_out_if.source pick_out
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  edfrm_pkg::state_t state, state_next;

  // Scan position: slot index currently at the head of the ring
  logic [IDX_W-1:0] cnt;
  logic             scan_last;

  // Task that was last handed out
  logic [IDX_W-1:0] active_slot;
  logic             active_valid;

  logic in_beat, wr_beat, sched_beat, load_out;

  edfrm_pkg::slot_rec_t   wr_rec;
  edfrm_pkg::slot_rec_t   recs [NUM_TASKS];
  edfrm_pkg::cell_ctrl_t  cctrl [NUM_TASKS];
  edfrm_pkg::pick_ctrl_t  pctrl;

  logic             pk_found;
  logic [IDX_W-1:0] pk_idx;
  logic [1:0]       pk_cls;
  logic [IDX_W+3:0] pk_idx_ext;

  assign in_beat    = task_in.valid && task_in.ready;
  assign wr_beat    = in_beat && (task_in.mode == edfrm_pkg::MODE_WRITE);
  assign sched_beat = in_beat && (task_in.mode == edfrm_pkg::MODE_SCHED);
  assign scan_last  = (cnt == IDX_W'(NUM_TASKS - 1));

  assign wr_rec.cls      = task_in.task_class;
  assign wr_rec.status   = task_in.task_status;
  assign wr_rec.prio     = task_in.priority_req;
  assign wr_rec.deadline = task_in.deadline;

  // ---------------------------------------------------------------- ring of slot cells
  // During a scan every cell takes its upper neighbour's record, so slot cnt sits in
  // cell 0; after NUM_TASKS shifts every record is back in its own cell.
  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
    localparam int NXT = (i + 1) % NUM_TASKS;

    always_comb begin
      cctrl[i].load  = wr_beat && (int'(task_in.slot) == i);
      cctrl[i].shift = (state == edfrm_pkg::S_SCAN);
      // previous active task back to ready, unless the call blocks
      cctrl[i].clr   = sched_beat && active_valid && !task_in.blocking_call &&
                       (active_slot == IDX_W'(i));
    end

    edfrm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (cctrl[i]),
      .wr_rec  (wr_rec),
      .nbr_rec (recs[NXT]),
      .rec     (recs[i])
    );
  end

  // ---------------------------------------------------------------- picker at the head
  assign pctrl.start = sched_beat;
  assign pctrl.step  = (state == edfrm_pkg::S_SCAN);

  edfrm_pick #(.NUM_TASKS(NUM_TASKS)) u_pick (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (pctrl),
    .head     (recs[0]),
    .head_idx (cnt),
    .found    (pk_found),
    .pick_idx (pk_idx),
    .pick_cls (pk_cls)
  );

  assign pk_idx_ext = {4'b0, pk_idx};

  // ---------------------------------------------------------------- control
  always_comb begin
    state_next = state;
    case (state)
      edfrm_pkg::S_IDLE: if (sched_beat) state_next = edfrm_pkg::S_SCAN;
      edfrm_pkg::S_SCAN: if (scan_last) state_next = edfrm_pkg::S_EMIT;
      edfrm_pkg::S_EMIT: if (load_out) state_next = edfrm_pkg::S_IDLE;
      default:           state_next = edfrm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    task_in.ready = 1'b0;
    load_out      = 1'b0;
    case (state)
      edfrm_pkg::S_IDLE: task_in.ready = 1'b1;
      edfrm_pkg::S_SCAN: ;
      // wait until the result register is free
      edfrm_pkg::S_EMIT: load_out = !pick_out.valid || pick_out.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= edfrm_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == edfrm_pkg::S_SCAN) begin
        cnt <= scan_last ? '0 : cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_slot  <= '0;
      active_valid <= 1'b0;
    end else if (load_out) begin
      active_slot  <= pk_idx;
      active_valid <= pk_found;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pick_out.valid <= 1'b0;
    end else if (load_out) begin
      pick_out.valid <= 1'b1;
    end else if (pick_out.ready) begin
      pick_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pick_out.chosen_slot  <= pk_idx_ext[3:0];
      pick_out.found        <= pk_found;
      pick_out.chosen_class <= pk_cls;
    end
  end

  // ---------------------------------------------------------------- checks
  a_idle_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == edfrm_pkg::S_IDLE) |-> (cnt == '0))
    else $error("scan counter not parked while idle");

  a_found_cls: assert property (@(posedge clk) disable iff (rst)
    (pick_out.valid && pick_out.found) |-> (pick_out.chosen_class != edfrm_pkg::CLASS_NONE))
    else $error("found task reported without class");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (pick_out.valid && !pick_out.found) |->
      ((pick_out.chosen_slot == 4'd0) && (pick_out.chosen_class == edfrm_pkg::CLASS_NONE)))
    else $error("empty result not zeroed");

  a_active: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (active_valid == pick_out.found))
    else $error("active task disagrees with result");

  a_emit_after_scan: assert property (@(posedge clk) disable iff (rst)
    ((state == edfrm_pkg::S_SCAN) && scan_last) |=> (state == edfrm_pkg::S_EMIT))
    else $error("scan did not end in emit");

endmodule

FILE: hdl/edfrm_cell.sv
module edfrm_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  edfrm_pkg::cell_ctrl_t ctrl,
  input  edfrm_pkg::slot_rec_t  wr_rec,
  input  edfrm_pkg::slot_rec_t  nbr_rec,
  output edfrm_pkg::slot_rec_t  rec
);

  always_ff @(posedge clk) begin
    if (rst) begin
      rec <= '0;
    end else if (ctrl.load) begin
      rec <= wr_rec;
    end else if (ctrl.shift) begin
      rec <= nbr_rec;
    end else if (ctrl.clr) begin
      rec.status <= edfrm_pkg::ST_READY;
    end
  end

endmodule

FILE: hdl/edfrm_pick.sv
module edfrm_pick #(
  parameter int NUM_TASKS = edfrm_pkg::NUM_TASKS_DEF,
  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  edfrm_pkg::pick_ctrl_t ctrl,
  input  edfrm_pkg::slot_rec_t head,
  input  logic [IDX_W-1:0]     head_idx,
  output logic                 found,
  output logic [IDX_W-1:0]     pick_idx,
  output logic [1:0]           pick_cls
);

  // Earliest deadline candidate
  logic             edf_have;
  logic [IDX_W-1:0] edf_idx;
  logic [31:0]      edf_dl;
  // Rate monotonic candidates, medium and periodic
  logic             med_have, per_have;
  logic [IDX_W-1:0] med_idx, per_idx;
  logic [7:0]       med_prio, per_prio;

  logic edf_take, med_take, per_take;

  always_comb begin
    edf_take = ctrl.step && (head.cls == edfrm_pkg::CLASS_APER) &&
               (!edf_have || (edf_dl > head.deadline));
    med_take = ctrl.step && (head.cls == edfrm_pkg::CLASS_MED) &&
               (med_have ? ((head.status == edfrm_pkg::ST_READY) && (med_prio > head.prio))
                         : (head.status != edfrm_pkg::ST_SUSP));
    per_take = ctrl.step && (head.cls == edfrm_pkg::CLASS_PER) &&
               (per_have ? ((head.status == edfrm_pkg::ST_READY) && (per_prio > head.prio))
                         : (head.status != edfrm_pkg::ST_SUSP));
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.start) begin
      edf_have <= 1'b0;
      med_have <= 1'b0;
      per_have <= 1'b0;
    end else begin
      if (edf_take) edf_have <= 1'b1;
      if (med_take) med_have <= 1'b1;
      if (per_take) per_have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (edf_take) begin
      edf_idx <= head_idx;
      edf_dl  <= head.deadline;
    end
    if (med_take) begin
      med_idx  <= head_idx;
      med_prio <= head.prio;
    end
    if (per_take) begin
      per_idx  <= head_idx;
      per_prio <= head.prio;
    end
  end

  always_comb begin
    found    = 1'b1;
    pick_idx = edf_idx;
    pick_cls = edfrm_pkg::CLASS_APER;
    if (edf_have) begin
      pick_idx = edf_idx;
    end else if (med_have) begin
      pick_idx = med_idx;
      pick_cls = edfrm_pkg::CLASS_MED;
    end else if (per_have) begin
      pick_idx = per_idx;
      pick_cls = edfrm_pkg::CLASS_PER;
    end else begin
      found    = 1'b0;
      pick_idx = '0;
      pick_cls = edfrm_pkg::CLASS_NONE;
    end
  end

endmodule
